### rtl/look_at_view_matrix_macros.svh
// ----------------------------------------------------------------------------
// Look-at view matrix assertion macros
// Shorthand for clocked checks with an active-low asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define LAV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("look_at_view_matrix: same-cycle check failed");

// Check the consequent in the cycle after the antecedent.
`define LAV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("look_at_view_matrix: next-cycle check failed");

`endif

### rtl/lav_pkg.sv
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Widths, row codes and constants shared by the view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int ELEM_W        = 18;
    localparam int TRANS_W       = 32;
    localparam int ROW_W         = 2;

    // the largest magnitude is brought into [2^29, 2^30) before the square root
    localparam int NORM_BITS     = 30;

    localparam logic [ROW_W-1:0] ROW_RIGHT = 2'd0;
    localparam logic [ROW_W-1:0] ROW_UP    = 2'd1;
    localparam logic [ROW_W-1:0] ROW_FWD   = 2'd2;
    localparam logic [ROW_W-1:0] ROW_CONST = 2'd3;

    localparam logic signed [31:0] ELEM_MAX = 32'sd131071;
    localparam logic signed [31:0] ELEM_MIN = -32'sd131072;

    localparam logic [32:0] SAT_POS_LIM = 33'h0_7FFF_FFFF;
    localparam logic [32:0] SAT_NEG_LIM = 33'h0_8000_0000;
    localparam logic [TRANS_W-1:0] TRANS_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [TRANS_W-1:0] TRANS_NEG_MIN = 32'h8000_0000;
    localparam logic [TRANS_W-1:0] TRANS_ONE     = 32'h0001_0000;

endpackage

### rtl/lav_ifs.sv
// ----------------------------------------------------------------------------
// Look-at view matrix channels
// Valid/ready interfaces for the camera word and the matrix row word.
// ----------------------------------------------------------------------------
interface lav_item_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lav_pkg::COORD_W-1:0]   eye_x;
    logic signed [lav_pkg::COORD_W-1:0]   eye_y;
    logic signed [lav_pkg::COORD_W-1:0]   eye_z;
    logic signed [lav_pkg::COORD_W-1:0]   target_x;
    logic signed [lav_pkg::COORD_W-1:0]   target_y;
    logic signed [lav_pkg::COORD_W-1:0]   target_z;
    logic signed [lav_pkg::COORD_W-1:0]   up_x;
    logic signed [lav_pkg::COORD_W-1:0]   up_y;
    logic signed [lav_pkg::COORD_W-1:0]   up_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               up_x, up_y, up_z,
        input  ready
    );
    modport sink (
        input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               up_x, up_y, up_z,
        output ready
    );
endinterface

interface lav_row_if;
    logic                                 valid;
    logic                                 ready;
    logic [lav_pkg::ROW_W-1:0]            row_index;
    logic signed [lav_pkg::ELEM_W-1:0]    elem_first;
    logic signed [lav_pkg::ELEM_W-1:0]    elem_second;
    logic signed [lav_pkg::ELEM_W-1:0]    elem_third;
    logic signed [lav_pkg::TRANS_W-1:0]   translation;
    logic                                 degenerate;
    logic                                 last_row;

    modport source (
        output valid, row_index, elem_first, elem_second, elem_third,
               translation, degenerate, last_row,
        input  ready
    );
    modport sink (
        input  valid, row_index, elem_first, elem_second, elem_third,
               translation, degenerate, last_row,
        output ready
    );
endinterface

### rtl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// Look-at view matrix
// Camera eye/target/up in signed Q16.16 in, four view matrix rows out.
// ----------------------------------------------------------------------------
//
//  channel  dir  word                                   accepted when
//  -------  ---  -------------------------------------  ------------------
//  item     in   eye, target, up (x, y, z; Q16.16)      valid && ready
//  row      out  row_index, 3 elements, translation,    valid && ready
//                degenerate, last_row
//
//  One camera word yields four row words, one per cycle while row.ready is
//  high; while rows are pending, a new camera word is taken only as the
//  single row port drains the last row from the output register. The path
//  to the first row runs through three normalizers of FRAC_BITS + 42
//  stages each, dominated by the 32-stage square root and the FRAC_BITS + 2
//  stage dividers.
//  Reset clears all valid bits and the row sequencer; payload is not reset.
//  The whole pipeline advances together; a stalled row port freezes every
//  stage, so nothing is lost or repeated. item.ready follows that advance.
//
module look_at_view_matrix #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lav_item_if.sink      item,
    lav_row_if.source     row
);

    localparam int CW  = lav_pkg::COORD_W;
    localparam int QW  = FRAC_BITS + 2;
    localparam int EW  = lav_pkg::ELEM_W;
    localparam int TW  = lav_pkg::TRANS_W;
    localparam int W1  = CW + 1;
    localparam int W2  = CW + QW + 1;
    localparam int W3  = 2 * QW + 1;
    localparam int SW1 = 6 * CW;
    localparam int SW2 = 3 * CW + 3 * QW + 1;
    localparam int SW3 = 3 * CW + 6 * QW + 1;

    // global advance: the row sequencer is free or hands off its last row
    logic adv;

    // input register
    logic                  iv_reg;
    logic [2:0][CW-1:0]    eye_reg;
    logic [2:0][CW-1:0]    up_reg;
    logic [2:0][W1-1:0]    fr_reg;

    // forward normalize
    logic                  n1_valid;
    logic [2:0][QW-1:0]    n1_vec;
    logic                  n1_ok;
    logic [SW1-1:0]        n1_side;
    logic [2:0][CW-1:0]    n1_eye;
    logic [2:0][CW-1:0]    n1_up;

    // right = up x forward
    logic                  c1_valid;
    logic [2:0][W2-1:0]    c1_vec;
    logic [SW2-1:0]        c1_side;

    // right normalize
    logic                  n2_valid;
    logic [2:0][QW-1:0]    n2_vec;
    logic                  n2_ok;
    logic [SW2-1:0]        n2_side;
    logic [2:0][CW-1:0]    n2_eye;
    logic [2:0][QW-1:0]    n2_fwd;
    logic                  n2_okf;

    // true up = forward x right
    logic                  c2_valid;
    logic [2:0][W3-1:0]    c2_vec;
    logic [SW3-1:0]        c2_side;

    // true up normalize
    logic                  n3_valid;
    logic [2:0][QW-1:0]    n3_vec;
    logic                  n3_ok;
    logic [SW3-1:0]        n3_side;
    logic [2:0][CW-1:0]    n3_eye;
    logic [2:0][QW-1:0]    n3_fwd;
    logic [2:0][QW-1:0]    n3_right;
    logic                  n3_deg;

    // translation column
    logic                       t_valid;
    logic [2:0][2:0][EW-1:0]    t_elem;
    logic [2:0][TW-1:0]         t_trans;
    logic                       t_deg;

    // row sequencer and output register
    logic                       busy_reg;
    logic [lav_pkg::ROW_W-1:0]  row_reg;
    logic [2:0][2:0][EW-1:0]    elem_reg;
    logic [2:0][TW-1:0]         trans_reg;
    logic                       deg_reg;

    assign adv        = !busy_reg || (row.ready && (row_reg == lav_pkg::ROW_CONST));
    assign item.ready = adv;

    // take the camera word and form target minus eye
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else if (adv)
        begin
            iv_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            eye_reg   <= {item.eye_z, item.eye_y, item.eye_x};
            up_reg    <= {item.up_z, item.up_y, item.up_x};
            fr_reg[0] <= W1'(item.target_x) - W1'(item.eye_x);
            fr_reg[1] <= W1'(item.target_y) - W1'(item.eye_y);
            fr_reg[2] <= W1'(item.target_z) - W1'(item.eye_z);
        end
    end

    lav_norm #(
        .W         (W1),
        .FRAC_BITS (FRAC_BITS),
        .SW        (SW1)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (iv_reg),
        .in_vec    (fr_reg),
        .in_side   ({up_reg, eye_reg}),
        .out_valid (n1_valid),
        .out_vec   (n1_vec),
        .out_ok    (n1_ok),
        .out_side  (n1_side)
    );

    assign n1_eye = n1_side[3*CW-1:0];
    assign n1_up  = n1_side[6*CW-1:3*CW];

    lav_cross #(
        .AW (CW),
        .BW (QW),
        .SW (SW2)
    ) u_cross_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (n1_valid),
        .in_a      (n1_up),
        .in_b      (n1_vec),
        .in_side   ({n1_ok, n1_vec, n1_eye}),
        .out_valid (c1_valid),
        .out_vec   (c1_vec),
        .out_side  (c1_side)
    );

    lav_norm #(
        .W         (W2),
        .FRAC_BITS (FRAC_BITS),
        .SW        (SW2)
    ) u_norm_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (c1_valid),
        .in_vec    (c1_vec),
        .in_side   (c1_side),
        .out_valid (n2_valid),
        .out_vec   (n2_vec),
        .out_ok    (n2_ok),
        .out_side  (n2_side)
    );

    assign n2_eye = n2_side[3*CW-1:0];
    assign n2_fwd = n2_side[3*CW+3*QW-1:3*CW];
    assign n2_okf = n2_side[SW2-1];

    lav_cross #(
        .AW (QW),
        .BW (QW),
        .SW (SW3)
    ) u_cross_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (n2_valid),
        .in_a      (n2_fwd),
        .in_b      (n2_vec),
        .in_side   ({!(n2_okf && n2_ok), n2_vec, n2_fwd, n2_eye}),
        .out_valid (c2_valid),
        .out_vec   (c2_vec),
        .out_side  (c2_side)
    );

    lav_norm #(
        .W         (W3),
        .FRAC_BITS (FRAC_BITS),
        .SW        (SW3)
    ) u_norm_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (c2_valid),
        .in_vec    (c2_vec),
        .in_side   (c2_side),
        .out_valid (n3_valid),
        .out_vec   (n3_vec),
        .out_ok    (n3_ok),
        .out_side  (n3_side)
    );

    assign n3_eye   = n3_side[3*CW-1:0];
    assign n3_fwd   = n3_side[3*CW+3*QW-1:3*CW];
    assign n3_right = n3_side[3*CW+6*QW-1:3*CW+3*QW];
    // true up may be zero only when right already was; its flag adds nothing
    assign n3_deg   = n3_side[SW3-1] || (1'b0 && n3_ok);

    lav_trans #(
        .FRAC_BITS (FRAC_BITS)
    ) u_trans (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (n3_valid),
        .in_axis   ({n3_fwd, n3_vec, n3_right}),
        .in_eye    (n3_eye),
        .in_deg    (n3_deg),
        .out_valid (t_valid),
        .out_elem  (t_elem),
        .out_trans (t_trans),
        .out_deg   (t_deg)
    );

    // row sequencer: load a finished matrix, then step through four rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= lav_pkg::ROW_RIGHT;
        end
        else if (adv)
        begin
            busy_reg <= t_valid;
            row_reg  <= lav_pkg::ROW_RIGHT;
        end
        else if (row.ready)
        begin
            row_reg <= row_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && t_valid)
        begin
            elem_reg  <= t_elem;
            trans_reg <= t_trans;
            deg_reg   <= t_deg;
        end
    end

    always_comb
    begin
        row.valid      = busy_reg;
        row.row_index  = row_reg;
        row.degenerate = deg_reg;
        row.last_row   = 1'b0;
        unique case (row_reg)
            lav_pkg::ROW_RIGHT:
            begin
                row.elem_first  = elem_reg[0][0];
                row.elem_second = elem_reg[0][1];
                row.elem_third  = elem_reg[0][2];
                row.translation = trans_reg[0];
            end
            lav_pkg::ROW_UP:
            begin
                row.elem_first  = elem_reg[1][0];
                row.elem_second = elem_reg[1][1];
                row.elem_third  = elem_reg[1][2];
                row.translation = trans_reg[1];
            end
            lav_pkg::ROW_FWD:
            begin
                row.elem_first  = elem_reg[2][0];
                row.elem_second = elem_reg[2][1];
                row.elem_third  = elem_reg[2][2];
                row.translation = trans_reg[2];
            end
            lav_pkg::ROW_CONST:
            begin
                row.elem_first  = '0;
                row.elem_second = '0;
                row.elem_third  = '0;
                row.translation = lav_pkg::TRANS_ONE;
                row.last_row    = 1'b1;
            end
            default:
            begin
                row.elem_first  = '0;
                row.elem_second = '0;
                row.elem_third  = '0;
                row.translation = '0;
            end
        endcase
    end

endmodule

### rtl/lav_norm.sv
// ----------------------------------------------------------------------------
// Look-at view matrix vector normalizer
// Pipelined 3-vector normalize: range scaling, square root, three dividers.
// ----------------------------------------------------------------------------
module lav_norm #(
    parameter int W         = 33,
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
    parameter int SW        = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [2:0][W-1:0]           in_vec,
    input  logic [SW-1:0]               in_side,
    output logic                        out_valid,
    output logic [2:0][FRAC_BITS+1:0]   out_vec,
    output logic                        out_ok,
    output logic [SW-1:0]               out_side
);

    localparam int MW  = lav_pkg::NORM_BITS;
    localparam int LW  = $clog2(W);
    localparam int SQW = 2 * MW + 2;
    localparam int RW  = SQW + 1;
    localparam int SQS = MW + 2;
    localparam int QW  = FRAC_BITS + 2;
    localparam int DW  = MW + FRAC_BITS + 2;
    localparam int CW  = SW + 4 + 3 * MW;
    localparam int DCW = SW + 4;

    // magnitudes and signs
    logic                   v1_reg;
    logic [2:0][W-1:0]      mag1_reg;
    logic [2:0]             sgn1_reg;
    logic [SW-1:0]          side1_reg;
    // largest magnitude
    logic                   v2_reg;
    logic [2:0][W-1:0]      mag2_reg;
    logic [W-1:0]           mx2_reg;
    logic [2:0]             sgn2_reg;
    logic [SW-1:0]          side2_reg;
    // leading one
    logic                   v3_reg;
    logic [2:0][W-1:0]      mag3_reg;
    logic [LW-1:0]          lead3_reg;
    logic                   zero3_reg;
    logic [2:0]             sgn3_reg;
    logic [SW-1:0]          side3_reg;
    // scaled magnitudes
    logic                   v4_reg;
    logic [2:0][MW-1:0]     m4_reg;
    logic                   zero4_reg;
    logic [2:0]             sgn4_reg;
    logic [SW-1:0]          side4_reg;
    // squares and sum
    logic                   v5_reg;
    logic [2:0][2*MW-1:0]   sq5_reg;
    logic [CW-1:0]          c5_reg;
    logic                   v6_reg;
    logic [SQW-1:0]         sum6_reg;
    logic [CW-1:0]          c6_reg;
    // square root stages
    logic                   svld_reg [SQS];
    logic [RW-1:0]          sv_reg   [SQS];
    logic [RW-1:0]          sr_reg   [SQS];
    logic [CW-1:0]          sc_reg   [SQS];
    // dividend set-up
    logic                   v7_reg;
    logic [2:0][DW-1:0]     n7_reg;
    logic [DW-1:0]          len7_reg;
    logic [DCW-1:0]         dc7_reg;
    // divider stages
    logic                   dvld_reg [QW];
    logic [2:0][DW-1:0]     dr_reg   [QW];
    logic [2:0][QW-1:0]     dq_reg   [QW];
    logic [DW-1:0]          dl_reg   [QW];
    logic [DCW-1:0]         dc_reg   [QW];
    // output
    logic                   out_valid_reg;
    logic [2:0][QW-1:0]     out_vec_reg;
    logic                   out_ok_reg;
    logic [SW-1:0]          out_side_reg;

    logic [2:0][W-1:0]      mag1_next;
    logic [W-1:0]           mx2_next;
    logic [LW-1:0]          lead3_next;
    logic [2:0][MW-1:0]     m4_next;
    logic [LW-1:0]          sh4;
    logic [2:0][DW-1:0]     n7_next;
    logic [DW-1:0]          len7_next;
    logic [CW-1:0]          sc_last;
    logic [2:0][MW-1:0]     m_last;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag1_next[i] = in_vec[i][W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
        end
        mx2_next = mag1_reg[0];
        if (mag1_reg[1] > mx2_next)
        begin
            mx2_next = mag1_reg[1];
        end
        if (mag1_reg[2] > mx2_next)
        begin
            mx2_next = mag1_reg[2];
        end
        lead3_next = '0;
        for (int b = 0; b < W; b++)
        begin
            if (mx2_reg[b])
            begin
                lead3_next = LW'(b);
            end
        end
        sh4 = '0;
        for (int i = 0; i < 3; i++)
        begin
            m4_next[i] = '0;
        end
        if (lead3_reg >= LW'(MW))
        begin
            sh4 = lead3_reg - LW'(MW - 1);
            for (int i = 0; i < 3; i++)
            begin
                m4_next[i] = MW'(mag3_reg[i] >> sh4);
            end
        end
        else
        begin
            sh4 = LW'(MW - 1) - lead3_reg;
            for (int i = 0; i < 3; i++)
            begin
                m4_next[i] = MW'(mag3_reg[i] << sh4);
            end
        end
        // dividend rounds to nearest: add half the length
        sc_last   = sc_reg[SQS-1];
        m_last    = sc_last[3*MW-1:0];
        len7_next = DW'(sr_reg[SQS-1]);
        for (int i = 0; i < 3; i++)
        begin
            n7_next[i] = (DW'(m_last[i]) << FRAC_BITS) + (len7_next >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= svld_reg[SQS-1];
            out_valid_reg <= dvld_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag1_reg  <= mag1_next;
            sgn1_reg  <= {in_vec[2][W-1], in_vec[1][W-1], in_vec[0][W-1]};
            side1_reg <= in_side;

            mag2_reg  <= mag1_reg;
            mx2_reg   <= mx2_next;
            sgn2_reg  <= sgn1_reg;
            side2_reg <= side1_reg;

            mag3_reg  <= mag2_reg;
            lead3_reg <= lead3_next;
            zero3_reg <= (mx2_reg == '0);
            sgn3_reg  <= sgn2_reg;
            side3_reg <= side2_reg;

            m4_reg    <= m4_next;
            zero4_reg <= zero3_reg;
            sgn4_reg  <= sgn3_reg;
            side4_reg <= side3_reg;

            for (int i = 0; i < 3; i++)
            begin
                sq5_reg[i] <= (2*MW)'(m4_reg[i]) * (2*MW)'(m4_reg[i]);
            end
            c5_reg    <= {side4_reg, zero4_reg, sgn4_reg, m4_reg};

            sum6_reg  <= SQW'(sq5_reg[0]) + SQW'(sq5_reg[1]) + SQW'(sq5_reg[2]);
            c6_reg    <= c5_reg;

            n7_reg    <= n7_next;
            len7_reg  <= len7_next;
            dc7_reg   <= sc_last[CW-1:3*MW];
        end
    end

    // floor square root, each stage deciding the next result bit
    for (genvar k = 0; k < SQS; k++)
    begin : g_sqrt
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQS - 1 - k));
        logic          vld_prev;
        logic [RW-1:0] v_prev;
        logic [RW-1:0] r_prev;
        logic [CW-1:0] c_prev;
        logic [RW-1:0] trial;

        if (k == 0)
        begin : g_first
            assign vld_prev = v6_reg;
            assign v_prev   = RW'(sum6_reg);
            assign r_prev   = '0;
            assign c_prev   = c6_reg;
        end
        else
        begin : g_rest
            assign vld_prev = svld_reg[k-1];
            assign v_prev   = sv_reg[k-1];
            assign r_prev   = sr_reg[k-1];
            assign c_prev   = sc_reg[k-1];
        end

        assign trial = r_prev + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                svld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                svld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sc_reg[k] <= c_prev;
                if (v_prev >= trial)
                begin
                    sv_reg[k] <= v_prev - trial;
                    sr_reg[k] <= (r_prev >> 1) + BIT;
                end
                else
                begin
                    sv_reg[k] <= v_prev;
                    sr_reg[k] <= r_prev >> 1;
                end
            end
        end
    end

    // restoring division, one quotient bit per stage for all three lanes
    for (genvar j = 0; j < QW; j++)
    begin : g_div
        localparam int P = QW - 1 - j;
        logic                vld_prev;
        logic [2:0][DW-1:0]  r_prev;
        logic [2:0][QW-1:0]  q_prev;
        logic [DW-1:0]       l_prev;
        logic [DCW-1:0]      c_prev;
        logic [DW-1:0]       dsh;

        if (j == 0)
        begin : g_first
            assign vld_prev = v7_reg;
            assign r_prev   = n7_reg;
            assign q_prev   = '0;
            assign l_prev   = len7_reg;
            assign c_prev   = dc7_reg;
        end
        else
        begin : g_rest
            assign vld_prev = dvld_reg[j-1];
            assign r_prev   = dr_reg[j-1];
            assign q_prev   = dq_reg[j-1];
            assign l_prev   = dl_reg[j-1];
            assign c_prev   = dc_reg[j-1];
        end

        assign dsh = l_prev << P;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dvld_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dvld_reg[j] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dl_reg[j] <= l_prev;
                dc_reg[j] <= c_prev;
                for (int i = 0; i < 3; i++)
                begin
                    if (r_prev[i] >= dsh)
                    begin
                        dr_reg[j][i] <= r_prev[i] - dsh;
                        dq_reg[j][i] <= q_prev[i] | (QW'(1) << P);
                    end
                    else
                    begin
                        dr_reg[j][i] <= r_prev[i];
                        dq_reg[j][i] <= q_prev[i];
                    end
                end
            end
        end
    end

    // restore signs; a zero vector comes out as zeros
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dc_reg[QW-1][3])
                begin
                    out_vec_reg[i] <= '0;
                end
                else if (dc_reg[QW-1][i])
                begin
                    out_vec_reg[i] <= -dq_reg[QW-1][i];
                end
                else
                begin
                    out_vec_reg[i] <= dq_reg[QW-1][i];
                end
            end
            out_ok_reg   <= !dc_reg[QW-1][3];
            out_side_reg <= dc_reg[QW-1][DCW-1:4];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vec   = out_vec_reg;
    assign out_ok    = out_ok_reg;
    assign out_side  = out_side_reg;

endmodule

### rtl/lav_cross.sv
// ----------------------------------------------------------------------------
// Look-at view matrix cross product
// Two-stage a x b: six registered products, then three differences.
// ----------------------------------------------------------------------------
module lav_cross #(
    parameter int AW = 32,
    parameter int BW = 18,
    parameter int SW = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  logic [2:0][AW-1:0]     in_a,
    input  logic [2:0][BW-1:0]     in_b,
    input  logic [SW-1:0]          in_side,
    output logic                   out_valid,
    output logic [2:0][AW+BW:0]    out_vec,
    output logic [SW-1:0]          out_side
);

    localparam int PW = AW + BW;
    localparam int RW = PW + 1;

    logic                  p_vld_reg;
    logic [5:0][PW-1:0]    p_reg;
    logic [SW-1:0]         p_side_reg;
    logic                  out_valid_reg;
    logic [2:0][RW-1:0]    out_vec_reg;
    logic [SW-1:0]         out_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_vld_reg     <= in_valid;
            out_valid_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0] <= PW'($signed(in_a[1])) * PW'($signed(in_b[2]));
            p_reg[1] <= PW'($signed(in_a[2])) * PW'($signed(in_b[1]));
            p_reg[2] <= PW'($signed(in_a[2])) * PW'($signed(in_b[0]));
            p_reg[3] <= PW'($signed(in_a[0])) * PW'($signed(in_b[2]));
            p_reg[4] <= PW'($signed(in_a[0])) * PW'($signed(in_b[1]));
            p_reg[5] <= PW'($signed(in_a[1])) * PW'($signed(in_b[0]));
            p_side_reg <= in_side;

            out_vec_reg[0] <= RW'($signed(p_reg[0])) - RW'($signed(p_reg[1]));
            out_vec_reg[1] <= RW'($signed(p_reg[2])) - RW'($signed(p_reg[3]));
            out_vec_reg[2] <= RW'($signed(p_reg[4])) - RW'($signed(p_reg[5]));
            out_side_reg   <= p_side_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vec   = out_vec_reg;
    assign out_side  = out_side_reg;

endmodule

### rtl/lav_trans.sv
// ----------------------------------------------------------------------------
// Look-at view matrix translation column
// Dot of each axis with eye, rounded, negated and saturated; element clamp.
// ----------------------------------------------------------------------------
module lav_trans #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            adv,
    input  logic                                            in_valid,
    input  logic [2:0][2:0][FRAC_BITS+1:0]                  in_axis,
    input  logic [2:0][lav_pkg::COORD_W-1:0]                in_eye,
    input  logic                                            in_deg,
    output logic                                            out_valid,
    output logic [2:0][2:0][lav_pkg::ELEM_W-1:0]            out_elem,
    output logic [2:0][lav_pkg::TRANS_W-1:0]                out_trans,
    output logic                                            out_deg
);

    localparam int QW  = FRAC_BITS + 2;
    localparam int CWD = lav_pkg::COORD_W;
    localparam int PW  = QW + CWD;
    localparam int SUW = PW + 2;
    localparam int RRW = SUW + 1;
    localparam int EW  = lav_pkg::ELEM_W;
    localparam int TW  = lav_pkg::TRANS_W;

    logic                          v1_reg;
    logic [2:0][2:0][PW-1:0]       prod1_reg;
    logic [2:0][2:0][QW-1:0]       axis1_reg;
    logic                          deg1_reg;
    logic                          v2_reg;
    logic [2:0][SUW-1:0]           sum2_reg;
    logic [2:0][2:0][QW-1:0]       axis2_reg;
    logic                          deg2_reg;
    logic                          out_valid_reg;
    logic [2:0][2:0][EW-1:0]       out_elem_reg;
    logic [2:0][TW-1:0]            out_trans_reg;
    logic                          out_deg_reg;

    logic [2:0][2:0][EW-1:0]       elem_next;
    logic [2:0][TW-1:0]            trans_next;
    logic signed [31:0]            ext;
    logic [SUW-1:0]                mag;
    logic [RRW-1:0]                rnd;

    always_comb
    begin
        ext = '0;
        mag = '0;
        rnd = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ext = 32'($signed(axis2_reg[r][c]));
                if (ext > lav_pkg::ELEM_MAX)
                begin
                    ext = lav_pkg::ELEM_MAX;
                end
                else if (ext < lav_pkg::ELEM_MIN)
                begin
                    ext = lav_pkg::ELEM_MIN;
                end
                elem_next[r][c] = EW'(ext);
            end
            // round magnitude to nearest, ties away from zero
            mag = sum2_reg[r][SUW-1] ? (~sum2_reg[r] + 1'b1) : sum2_reg[r];
            rnd = (RRW'(mag) + (RRW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (sum2_reg[r][SUW-1])
            begin
                trans_next[r] = (rnd > RRW'(lav_pkg::SAT_POS_LIM)) ?
                                lav_pkg::TRANS_POS_MAX : TW'(rnd);
            end
            else
            begin
                trans_next[r] = (rnd > RRW'(lav_pkg::SAT_NEG_LIM)) ?
                                lav_pkg::TRANS_NEG_MIN : TW'(-rnd);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod1_reg[r][c] <= PW'($signed(in_axis[r][c])) *
                                       PW'($signed(in_eye[c]));
                end
                sum2_reg[r] <= SUW'($signed(prod1_reg[r][0])) +
                               SUW'($signed(prod1_reg[r][1])) +
                               SUW'($signed(prod1_reg[r][2]));
            end
            axis1_reg     <= in_axis;
            deg1_reg      <= in_deg;
            axis2_reg     <= axis1_reg;
            deg2_reg      <= deg1_reg;
            out_elem_reg  <= elem_next;
            out_trans_reg <= trans_next;
            out_deg_reg   <= deg2_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_elem  = out_elem_reg;
    assign out_trans = out_trans_reg;
    assign out_deg   = out_deg_reg;

endmodule

### rtl/lav_check.sv
// ----------------------------------------------------------------------------
// Look-at view matrix port checker
// Watches the row port for row order, flags, stalls and the constant row.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_macros.svh"

module lav_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              row_valid,
    input  logic                              row_ready,
    input  logic [lav_pkg::ROW_W-1:0]         row_index,
    input  logic [lav_pkg::ELEM_W-1:0]        elem_first,
    input  logic [lav_pkg::ELEM_W-1:0]        elem_second,
    input  logic [lav_pkg::ELEM_W-1:0]        elem_third,
    input  logic [lav_pkg::TRANS_W-1:0]       translation,
    input  logic                              degenerate,
    input  logic                              last_row
);

    // rows of one matrix follow each other with no gap
    `LAV_ASSERT_NEXT(a_row_burst, clk, rst_n, row_valid && row_ready && !last_row, row_valid && (row_index == $past(row_index) + 2'd1))

    // last_row marks exactly the constant row
    `LAV_ASSERT_NOW(a_last_flag, clk, rst_n, row_valid, last_row == (row_index == lav_pkg::ROW_CONST))

    // constant row is 0, 0, 0, 1.0
    `LAV_ASSERT_NOW(a_const_row, clk, rst_n, row_valid && last_row, (elem_first == '0) && (elem_second == '0) && (elem_third == '0) && (translation == lav_pkg::TRANS_ONE))

    // degenerate holds across the rows of one matrix
    `LAV_ASSERT_NEXT(a_deg_held, clk, rst_n, row_valid && row_ready && !last_row, degenerate == $past(degenerate))

    // a stalled row word keeps its valid, index and translation
    `LAV_ASSERT_NEXT(a_stall_hold, clk, rst_n, row_valid && !row_ready, row_valid && $stable(row_index) && $stable(translation))

endmodule

bind look_at_view_matrix lav_check u_lav_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .row_valid   (row.valid),
    .row_ready   (row.ready),
    .row_index   (row.row_index),
    .elem_first  (row.elem_first),
    .elem_second (row.elem_second),
    .elem_third  (row.elem_third),
    .translation (row.translation),
    .degenerate  (row.degenerate),
    .last_row    (row.last_row)
);
